>>> rtl/core/quad_shape_validator_assert.svh
// assertion macros for the quad shape validator
`ifndef QUAD_SHAPE_VALIDATOR_ASSERT_SVH
`define QUAD_SHAPE_VALIDATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define QSV_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("qsv: same-cycle check failed");
`define QSV_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("qsv: next-cycle check failed");
`else
`define QSV_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define QSV_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

>>> rtl/core/qsv_pkg.sv
`timescale 1ns / 1ps
package qsv_pkg;

	localparam int COORD_WIDTH_DEF = 16;

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;
	localparam int MIN_W   = 12;
	localparam int DEV_W   = 17;
	localparam int K2_W    = 32;

	localparam logic [1:0] REG_MIN_SIDE  = 2'd0;
	localparam logic [1:0] REG_SIDE_DEV  = 2'd1;
	localparam logic [1:0] REG_DIAG_DEV  = 2'd2;

	localparam logic [MIN_W-1:0] MIN_SIDE_RST = 12'd0;
	localparam logic [DEV_W-1:0] DEV_RST      = 17'd6554;
	localparam logic [DEV_W-1:0] DEV_ONE      = 17'h10000;

	typedef struct packed {
		logic            pass_all;
		logic            fail_all;
		logic [K2_W-1:0] k2;
	} qsv_limit_t;

	// (1 - limit)^2 in Q0.32, with the two ends of the range as flags
	function automatic qsv_limit_t limit_of(input logic [DEV_W-1:0] dev);
		qsv_limit_t      r;
		logic [DEV_W-1:0] kf;
		logic [15:0]     k;
		kf = DEV_ONE - dev;
		k = kf[15:0];
		r.pass_all = dev > DEV_ONE;
		r.fail_all = dev == '0;
		r.k2 = K2_W'(k) * K2_W'(k);
		return r;
	endfunction

endpackage

>>> rtl/core/qsv_if.sv
`timescale 1ns / 1ps
interface qsv_in_if #(parameter int COORD_WIDTH = qsv_pkg::COORD_WIDTH_DEF);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] top_right_x;
	logic signed [COORD_WIDTH-1:0] top_right_y;
	logic signed [COORD_WIDTH-1:0] bottom_left_x;
	logic signed [COORD_WIDTH-1:0] bottom_left_y;
	logic signed [COORD_WIDTH-1:0] top_left_x;
	logic signed [COORD_WIDTH-1:0] top_left_y;
	logic signed [COORD_WIDTH-1:0] bottom_right_x;
	logic signed [COORD_WIDTH-1:0] bottom_right_y;

	modport source (
		output valid, top_right_x, top_right_y, bottom_left_x, bottom_left_y,
		       top_left_x, top_left_y, bottom_right_x, bottom_right_y,
		input  ready
	);
	modport sink (
		input  valid, top_right_x, top_right_y, bottom_left_x, bottom_left_y,
		       top_left_x, top_left_y, bottom_right_x, bottom_right_y,
		output ready
	);
endinterface

interface qsv_out_if;
	logic valid;
	logic ready;
	logic shape_ok;

	modport source (output valid, shape_ok, input ready);
	modport sink (input valid, shape_ok, output ready);
endinterface

>>> rtl/core/qsv_sq_len.sv
`timescale 1ns / 1ps
module qsv_sq_len #(
	parameter int COORD_WIDTH = qsv_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [COORD_WIDTH-1:0] ax,
	input  logic signed [COORD_WIDTH-1:0] ay,
	input  logic signed [COORD_WIDTH-1:0] bx,
	input  logic signed [COORD_WIDTH-1:0] by,
	output logic [2*COORD_WIDTH:0]        sq
);
	localparam int CW = COORD_WIDTH;

	logic signed [CW:0] ddx, ddy;
	logic [CW:0]        mx, my;
	logic [CW-1:0]      dx_s1, dy_s1;
	logic [2*CW-1:0]    sqx_s2, sqy_s2;
	logic [2*CW:0]      sq_s3;

	// differences never reach 2^CW in magnitude, so CW bits hold them
	assign ddx = {ax[CW-1], ax} - {bx[CW-1], bx};
	assign ddy = {ay[CW-1], ay} - {by[CW-1], by};
	assign mx  = ddx[CW] ? unsigned'(-ddx) : unsigned'(ddx);
	assign my  = ddy[CW] ? unsigned'(-ddy) : unsigned'(ddy);

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1  <= mx[CW-1:0];
			dy_s1  <= my[CW-1:0];
			sqx_s2 <= (2*CW)'(dx_s1) * (2*CW)'(dx_s1);
			sqy_s2 <= (2*CW)'(dy_s1) * (2*CW)'(dy_s1);
			sq_s3  <= {1'b0, sqx_s2} + {1'b0, sqy_s2};
		end
	end

	assign sq = sq_s3;
endmodule

>>> rtl/core/qsv_pair_check.sv
`timescale 1ns / 1ps
module qsv_pair_check #(
	parameter int COORD_WIDTH = qsv_pkg::COORD_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic [2*COORD_WIDTH:0] a,
	input  logic [2*COORD_WIDTH:0] b,
	input  qsv_pkg::qsv_limit_t    lim,
	output logic                   ok
);
	import qsv_pkg::*;

	localparam int GW  = 2 * COORD_WIDTH + 1;
	localparam int GPW = (GW > K2_W) ? GW : K2_W + 1;
	localparam int HW  = GPW - K2_W;
	localparam int RW  = GPW + K2_W;

	logic [GPW-1:0]       s_s4, g_s4, s_s5;
	logic                 gz_s4, gz_s5;
	logic [2*K2_W-1:0]    plo_s5;
	logic [HW+K2_W-1:0]   phi_s5;
	logic                 ok_s6;
	logic [RW-1:0]        lhs, rhs;
	logic                 a_le_b;

	assign a_le_b = a <= b;

	always_ff @(posedge clk) begin
		if (en) begin
			s_s4   <= GPW'(a_le_b ? a : b);
			g_s4   <= GPW'(a_le_b ? b : a);
			gz_s4  <= (a_le_b ? b : a) == '0;
			// g * k2 split into two partial products
			plo_s5 <= (2*K2_W)'(g_s4[K2_W-1:0]) * (2*K2_W)'(lim.k2);
			phi_s5 <= (HW+K2_W)'(g_s4[GPW-1:K2_W]) * (HW+K2_W)'(lim.k2);
			s_s5   <= s_s4;
			gz_s5  <= gz_s4;
			ok_s6  <= !gz_s5 && (lim.pass_all || (!lim.fail_all && lhs > rhs));
		end
	end

	assign lhs = {s_s5, {K2_W{1'b0}}};
	assign rhs = {phi_s5, {K2_W{1'b0}}} + RW'(plo_s5);
	assign ok  = ok_s6;
endmodule

>>> rtl/core/quad_shape_validator.sv
`timescale 1ns / 1ps
// quad_shape_validator: plausibility check of a quadrilateral as a rectangle
//
// in_item carries the four corners, each a signed coordinate with four
// fraction bits; out_item carries one shape_ok bit for every item taken.
// an item is moved when valid and ready are both high at a rising edge.
// three limits sit on the APB port: min side length at 0x0, side
// deviation at 0x4, diagonal deviation at 0x8; write them only while idle.
//
// results pass through the six-stage pipeline to out_item.valid:
// differences, squares, sums, ordering, partial products, final compare.
// one item can enter every cycle while the pipeline is not held (below).
// when out_item.ready is low with a result waiting, the whole pipeline
// holds; in_item.ready comes from a one-item skid register, so one more
// item is taken and parked before in_item.ready drops.
// arst_n clears all valid bits and skid, and loads the limit reset values
// (min side 0, both deviations 6554). no results are lost or repeated.
`include "quad_shape_validator_assert.svh"
module quad_shape_validator #(
	parameter int COORD_WIDTH = qsv_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [qsv_pkg::PADDR_W-1:0]   paddr,
	input  logic [qsv_pkg::PDATA_W-1:0]   pwdata,
	output logic [qsv_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	qsv_in_if.sink                        in_item,
	qsv_out_if.source                     out_item
);
	import qsv_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int GW = 2 * CW + 1;
	localparam int SW = (GW > 32) ? GW : 32;

	typedef struct packed {
		logic signed [CW-1:0] trx;
		logic signed [CW-1:0] try_c;
		logic signed [CW-1:0] blx;
		logic signed [CW-1:0] bly;
		logic signed [CW-1:0] tlx;
		logic signed [CW-1:0] tly;
		logic signed [CW-1:0] brx;
		logic signed [CW-1:0] bry;
	} quad_t;

	logic [MIN_W-1:0] min_q;
	logic [DEV_W-1:0] sdev_q, ddev_q;
	qsv_limit_t       slim_q, dlim_q;
	logic [31:0]      thr_q;
	logic [1:0]       ridx;
	logic             wr;

	quad_t in_quad, skid_q, src;
	logic  skid_v_q, src_v, en;
	logic  v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	logic [GW-1:0] top_sq, bot_sq, lft_sq, rgt_sq, d0_sq, d1_sq;
	logic          side_s4, side_s5, side_s6;
	logic          ok_tb, ok_lr, ok_dg;
	logic [SW-1:0] thr_w;

	// register port
	assign pready = 1'b1;
	assign ridx   = paddr[3:2];
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q  <= MIN_SIDE_RST;
			sdev_q <= DEV_RST;
			ddev_q <= DEV_RST;
		end else if (wr) begin
			unique case (ridx)
				REG_MIN_SIDE: min_q  <= pwdata[MIN_W-1:0];
				REG_SIDE_DEV: sdev_q <= pwdata[DEV_W-1:0];
				REG_DIAG_DEV: ddev_q <= pwdata[DEV_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			REG_MIN_SIDE: prdata = PDATA_W'(min_q);
			REG_SIDE_DEV: prdata = PDATA_W'(sdev_q);
			REG_DIAG_DEV: prdata = PDATA_W'(ddev_q);
			default:      prdata = '0;
		endcase
	end

	// thresholds derived from the limits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slim_q <= limit_of(DEV_RST);
			dlim_q <= limit_of(DEV_RST);
			thr_q  <= '0;
		end else begin
			slim_q <= limit_of(sdev_q);
			dlim_q <= limit_of(ddev_q);
			thr_q  <= {24'(min_q) * 24'(min_q), 8'h00};
		end
	end

	// input skid and stage enable
	assign in_quad = '{
		trx:   in_item.top_right_x,
		try_c: in_item.top_right_y,
		blx:   in_item.bottom_left_x,
		bly:   in_item.bottom_left_y,
		tlx:   in_item.top_left_x,
		tly:   in_item.top_left_y,
		brx:   in_item.bottom_right_x,
		bry:   in_item.bottom_right_y
	};

	assign in_item.ready = !skid_v_q;
	assign en            = !v_s6 || out_item.ready;
	assign src_v         = skid_v_q || in_item.valid;
	assign src           = skid_v_q ? skid_q : in_quad;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q <= 1'b0;
		end else if (en) begin
			skid_v_q <= 1'b0;
		end else if (in_item.valid && !skid_v_q) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!en && !skid_v_q) begin
			skid_q <= in_quad;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= src_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// squared lengths, stages one to three
	qsv_sq_len #(.COORD_WIDTH(CW)) u_top (
		.clk(clk), .en(en), .ax(src.trx), .ay(src.try_c), .bx(src.tlx), .by(src.tly),
		.sq(top_sq)
	);
	qsv_sq_len #(.COORD_WIDTH(CW)) u_bot (
		.clk(clk), .en(en), .ax(src.brx), .ay(src.bry), .bx(src.blx), .by(src.bly),
		.sq(bot_sq)
	);
	qsv_sq_len #(.COORD_WIDTH(CW)) u_lft (
		.clk(clk), .en(en), .ax(src.blx), .ay(src.bly), .bx(src.tlx), .by(src.tly),
		.sq(lft_sq)
	);
	qsv_sq_len #(.COORD_WIDTH(CW)) u_rgt (
		.clk(clk), .en(en), .ax(src.brx), .ay(src.bry), .bx(src.trx), .by(src.try_c),
		.sq(rgt_sq)
	);
	qsv_sq_len #(.COORD_WIDTH(CW)) u_d0 (
		.clk(clk), .en(en), .ax(src.trx), .ay(src.try_c), .bx(src.blx), .by(src.bly),
		.sq(d0_sq)
	);
	qsv_sq_len #(.COORD_WIDTH(CW)) u_d1 (
		.clk(clk), .en(en), .ax(src.tlx), .ay(src.tly), .bx(src.brx), .by(src.bry),
		.sq(d1_sq)
	);

	// pair tests, stages four to six
	qsv_pair_check #(.COORD_WIDTH(CW)) u_tb (
		.clk(clk), .en(en), .a(top_sq), .b(bot_sq), .lim(slim_q), .ok(ok_tb)
	);
	qsv_pair_check #(.COORD_WIDTH(CW)) u_lr (
		.clk(clk), .en(en), .a(lft_sq), .b(rgt_sq), .lim(slim_q), .ok(ok_lr)
	);
	qsv_pair_check #(.COORD_WIDTH(CW)) u_dg (
		.clk(clk), .en(en), .a(d0_sq), .b(d1_sq), .lim(dlim_q), .ok(ok_dg)
	);

	// minimum side test, aligned with the pair tests
	assign thr_w = SW'(thr_q);

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4 <= (SW'(top_sq) > thr_w) && (SW'(bot_sq) > thr_w)
			        && (SW'(lft_sq) > thr_w) && (SW'(rgt_sq) > thr_w);
			side_s5 <= side_s4;
			side_s6 <= side_s5;
		end
	end

	assign out_item.valid    = v_s6;
	assign out_item.shape_ok = side_s6 && ok_tb && ok_lr && ok_dg;

	`QSV_ASSERT_NXT(a_skid_fill, clk, arst_n, in_item.valid && in_item.ready && !en, skid_v_q)
	`QSV_ASSERT_NXT(a_skid_hold, clk, arst_n, skid_v_q && !en, skid_v_q && $stable(skid_q))
	`QSV_ASSERT_NXT(a_pipe_move, clk, arst_n, en && v_s5, v_s6)
	`QSV_ASSERT_IMP(a_lim_excl, clk, arst_n, slim_q.pass_all, !slim_q.fail_all)
endmodule

>>> test/quad_shape_validator_test.sv
`timescale 1ns / 1ps
module quad_shape_validator_test;
	import qsv_pkg::*;

	localparam int CW = COORD_WIDTH_DEF;
	localparam int CMAX = 2 ** (CW - 1) - 1;
	localparam int CMIN = -(2 ** (CW - 1));
	localparam logic [1:0] REG_UNUSED = 2'd3;

	typedef logic signed [CW-1:0] coord_t;

	typedef struct {
		coord_t tr_x;
		coord_t tr_y;
		coord_t bl_x;
		coord_t bl_y;
		coord_t tl_x;
		coord_t tl_y;
		coord_t br_x;
		coord_t br_y;
	} quad_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	qsv_in_if #(.COORD_WIDTH(CW)) quad_in ();
	qsv_out_if verdict_out ();

	quad_shape_validator #(.COORD_WIDTH(CW)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_item(quad_in.sink),
		.out_item(verdict_out.source)
	);

	logic [MIN_W-1:0] min_side_cfg = MIN_SIDE_RST;
	logic [DEV_W-1:0] side_dev_cfg = DEV_RST;
	logic [DEV_W-1:0] diag_dev_cfg = DEV_RST;

	quad_t quad_pending[$];
	quad_t cur_quad;
	bit verdicts_due[$];
	int quads_queued = 0;
	int quads_taken = 0;
	int verdicts_seen = 0;
	int mismatches = 0;
	int in_gap = 0;
	int out_hold = 0;
	bit in_idle = 1'b0;
	bit out_idle = 1'b0;
	bit want_ok;

	always #5 clk = ~clk;

	function automatic longint span_sq(coord_t ax, coord_t ay, coord_t bx, coord_t by);
		longint dx, dy;
		dx = longint'(ax) - longint'(bx);
		dy = longint'(ay) - longint'(by);
		return dx * dx + dy * dy;
	endfunction

	// exact 1 - shorter/longer < lim/2^16 for the lengths, tested on their squares
	function automatic bit pair_close(longint a, longint b, logic [DEV_W-1:0] lim);
		logic [127:0] lo, hi, k;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		if (hi == 0)
			return 1'b0;
		if (lim > DEV_ONE)
			return 1'b1;
		k = 128'(DEV_ONE - lim);
		return (lo << 32) > hi * k * k;
	endfunction

	function automatic bit side_long(longint sq);
		return sq > 256 * longint'(min_side_cfg) * longint'(min_side_cfg);
	endfunction

	function automatic bit shape_verdict(quad_t q);
		longint top, bottom, left, right, d0, d1;
		top = span_sq(q.tr_x, q.tr_y, q.tl_x, q.tl_y);
		bottom = span_sq(q.br_x, q.br_y, q.bl_x, q.bl_y);
		left = span_sq(q.bl_x, q.bl_y, q.tl_x, q.tl_y);
		right = span_sq(q.br_x, q.br_y, q.tr_x, q.tr_y);
		d0 = span_sq(q.tr_x, q.tr_y, q.bl_x, q.bl_y);
		d1 = span_sq(q.tl_x, q.tl_y, q.br_x, q.br_y);
		return pair_close(top, bottom, side_dev_cfg) && pair_close(left, right, side_dev_cfg)
			&& pair_close(d0, d1, diag_dev_cfg) && side_long(top) && side_long(bottom)
			&& side_long(left) && side_long(right);
	endfunction

	function automatic coord_t clip(int v);
		if (v > CMAX)
			return coord_t'(CMAX);
		if (v < CMIN)
			return coord_t'(CMIN);
		return coord_t'(v);
	endfunction

	function automatic quad_t corners(int trx, int tr_y, int blx, int bly, int tlx, int tly,
			int brx, int bry);
		quad_t q;
		q.tr_x = clip(trx);
		q.tr_y = clip(tr_y);
		q.bl_x = clip(blx);
		q.bl_y = clip(bly);
		q.tl_x = clip(tlx);
		q.tl_y = clip(tly);
		q.br_x = clip(brx);
		q.br_y = clip(bry);
		return q;
	endfunction

	function automatic int signed_rand(int m);
		return int'($urandom_range(0, 2 * m)) - m;
	endfunction

	function automatic int edge_value();
		case ($urandom_range(0, 4))
			0: return CMIN;
			1: return CMAX;
			2: return 0;
			3: return -1;
			default: return 1;
		endcase
	endfunction

	function automatic quad_t make_quad();
		int kind, span, px, py, qx, qy, ax, ay, bx, by, num, jit;
		logic [3:0] pick;
		kind = $urandom_range(0, 99);
		if (kind < 72) begin
			// near-rectangle: origin p, side vectors a and b roughly perpendicular
			span = ($urandom_range(0, 15) == 0) ? CMAX
				: (($urandom_range(0, 3) == 0) ? 4000 : 640);
			ax = signed_rand(span);
			ay = signed_rand(span);
			num = $urandom_range(16, 128);
			bx = -ay * num / 64;
			by = ax * num / 64;
			px = signed_rand(30000);
			py = signed_rand(30000);
			jit = $urandom_range(0, (((ax < 0 ? -ax : ax) + (ay < 0 ? -ay : ay))
				>> $urandom_range(3, 9)) + 1);
			return corners(px + ax + signed_rand(jit), py + ay + signed_rand(jit),
				px + bx + signed_rand(jit), py + by + signed_rand(jit),
				px + signed_rand(jit), py + signed_rand(jit),
				px + ax + bx + signed_rand(jit), py + ay + by + signed_rand(jit));
		end else if (kind < 86) begin
			return corners(int'(coord_t'($urandom)), int'(coord_t'($urandom)),
				int'(coord_t'($urandom)), int'(coord_t'($urandom)),
				int'(coord_t'($urandom)), int'(coord_t'($urandom)),
				int'(coord_t'($urandom)), int'(coord_t'($urandom)));
		end else if (kind < 95) begin
			// coincident corners
			px = signed_rand(2000);
			py = signed_rand(2000);
			qx = px + signed_rand(300);
			qy = py + signed_rand(300);
			pick = $urandom_range(0, 15);
			return corners(pick[0] ? qx : px, pick[0] ? qy : py, pick[1] ? qx : px,
				pick[1] ? qy : py, pick[2] ? qx : px, pick[2] ? qy : py,
				pick[3] ? qx : px, pick[3] ? qy : py);
		end
		return corners(edge_value(), edge_value(), edge_value(), edge_value(),
			edge_value(), edge_value(), edge_value(), edge_value());
	endfunction

	function automatic int pick_gap(bit on);
		int r;
		if (!on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic queue_quad(quad_t q);
		quad_pending.push_back(q);
		quads_queued++;
	endtask

	task automatic reg_write(input logic [1:0] idx, input logic [PDATA_W-1:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'({idx, 2'b00});
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_MIN_SIDE: min_side_cfg = data[MIN_W-1:0];
			REG_SIDE_DEV: side_dev_cfg = data[DEV_W-1:0];
			REG_DIAG_DEV: diag_dev_cfg = data[DEV_W-1:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		do @(negedge clk); while (quads_taken != quads_queued || verdicts_due.size() != 0);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			quad_in.valid <= 1'b0;
		end else begin
			if (quad_in.valid && quad_in.ready) begin
				verdicts_due.push_back(shape_verdict(cur_quad));
				quads_taken++;
			end
			if (!quad_in.valid || quad_in.ready) begin
				if (in_gap > 0) begin
					in_gap--;
					quad_in.valid <= 1'b0;
				end else if (quad_pending.size() != 0) begin
					cur_quad = quad_pending.pop_front();
					quad_in.top_right_x <= cur_quad.tr_x;
					quad_in.top_right_y <= cur_quad.tr_y;
					quad_in.bottom_left_x <= cur_quad.bl_x;
					quad_in.bottom_left_y <= cur_quad.bl_y;
					quad_in.top_left_x <= cur_quad.tl_x;
					quad_in.top_left_y <= cur_quad.tl_y;
					quad_in.bottom_right_x <= cur_quad.br_x;
					quad_in.bottom_right_y <= cur_quad.br_y;
					quad_in.valid <= 1'b1;
					in_gap = pick_gap(in_idle);
				end else begin
					quad_in.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (verdict_out.valid && verdict_out.ready) begin
				if (verdicts_due.size() == 0) begin
					if (mismatches < 10)
						$display("item %0d: shape_ok %0b with nothing expected", verdicts_seen,
							verdict_out.shape_ok);
					mismatches++;
				end else begin
					want_ok = verdicts_due.pop_front();
					if (verdict_out.shape_ok !== want_ok) begin
						if (mismatches < 10)
							$display("item %0d: shape_ok expected %0b, got %0b", verdicts_seen,
								want_ok, verdict_out.shape_ok);
						mismatches++;
					end
				end
				verdicts_seen++;
			end
			if (out_hold > 0) begin
				out_hold--;
				verdict_out.ready <= 1'b0;
			end else begin
				verdict_out.ready <= 1'b1;
				out_hold = pick_gap(out_idle);
			end
		end
	end

	initial begin
		#10_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int phase;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		quad_in.valid = 1'b0;
		quad_in.top_right_x = '0;
		quad_in.top_right_y = '0;
		quad_in.bottom_left_x = '0;
		quad_in.bottom_left_y = '0;
		quad_in.top_left_x = '0;
		quad_in.top_left_y = '0;
		quad_in.bottom_right_x = '0;
		quad_in.bottom_right_y = '0;
		verdict_out.ready = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (phase = 0; phase < 8; phase++) begin
			if (phase != 0) begin
				drain();
				case (phase)
					1: begin
						reg_write(REG_MIN_SIDE, 0);
						reg_write(REG_SIDE_DEV, 0);
						reg_write(REG_DIAG_DEV, 0);
					end
					2: begin
						reg_write(REG_MIN_SIDE, 4095);
						reg_write(REG_SIDE_DEV, 65536);
						reg_write(REG_DIAG_DEV, 65536);
					end
					3: begin
						reg_write(REG_MIN_SIDE, 10);
						reg_write(REG_SIDE_DEV, 131071);
						reg_write(REG_DIAG_DEV, 65537);
						reg_write(REG_UNUSED, $urandom);
					end
					4: begin
						reg_write(REG_MIN_SIDE, 32'hFFFF_F003);
						reg_write(REG_SIDE_DEV, 32'hFFFE_0001);
						reg_write(REG_DIAG_DEV, 65535);
					end
					default: begin
						reg_write(REG_MIN_SIDE, $urandom_range(0, 48));
						reg_write(REG_SIDE_DEV, $urandom_range(0, 65536));
						reg_write(REG_DIAG_DEV, $urandom_range(0, 65536));
					end
				endcase
				@(negedge clk);
			end
			in_idle = (phase % 4) != 1;
			out_idle = (phase % 4) != 2;

			case (phase)
				0: begin
					queue_quad(corners(160, 0, 0, 160, 0, 0, 160, 160));
					queue_quad(corners(320, 0, 0, 80, 0, 0, 320, 80));
					queue_quad(corners(113, 113, -113, 113, 0, 0, 0, 226));
					queue_quad(corners(0, 0, 0, 0, 0, 0, 0, 0));
					queue_quad(corners(CMAX, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX, CMAX));
					queue_quad(corners(CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN, CMIN));
					// top side of zero length
					queue_quad(corners(0, 0, 0, 160, 0, 0, 160, 160));
					// trapezoids just inside and just outside the side limit
					queue_quad(corners(1600, 0, -80, 1600, 0, 0, 1680, 1600));
					queue_quad(corners(1600, 0, -96, 1600, 0, 0, 1696, 1600));
					// parallelogram with unequal diagonals
					queue_quad(corners(1600, 0, 400, 1600, 0, 0, 2000, 1600));
					queue_quad(corners(-1, -1, -1, -1, -1, -1, -1, -1));
					// one diagonal of zero length
					queue_quad(corners(160, 0, 160, 0, 0, 0, 320, 0));
					queue_quad(corners(160, 0, 320, 0, 0, 0, 480, 0));
				end
				1: queue_quad(corners(160, 0, 0, 160, 0, 0, 160, 160));
				2: begin
					queue_quad(corners(CMAX, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX, CMAX));
					queue_quad(corners(32752, CMIN, CMIN, 32752, CMIN, CMIN, 32752, 32752));
				end
				3: begin
					queue_quad(corners(160, 0, 0, 160, 0, 0, 160, 160));
					queue_quad(corners(161, 0, 0, 161, 0, 0, 161, 161));
					queue_quad(corners(0, 0, 0, 161, 0, 0, 161, 161));
				end
				default: ;
			endcase
			repeat (185) queue_quad(make_quad());
		end

		drain();
		repeat (12) @(posedge clk);
		if (mismatches == 0 && verdicts_due.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/qsv_pkg.sv
rtl/core/qsv_if.sv
rtl/core/qsv_sq_len.sv
rtl/core/qsv_pair_check.sv
rtl/core/quad_shape_validator.sv
test/quad_shape_validator_test.sv
